FILE: hw/rtl/ghash_pkg.sv
`default_nettype none

package ghash_pkg;

	localparam int unsigned BLOCK_BITS  = 128;
	localparam int unsigned HALF_BITS   = 64;
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned TOTAL_W     = 61;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned PROD_BITS   = 2 * BLOCK_BITS - 1;

	// reduction polynomial in reflected byte form (x^0 in the msb)
	localparam logic [7:0] POLY_TOP = 8'he1;

	typedef enum logic [1:0] {
		KIND_AAD    = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	// prepared item handed from the input stage to the core
	typedef struct packed {
		kind_t                   kind;
		logic [BLOCK_BITS-1:0]   block;
		logic [COUNT_W-1:0]      nbytes;
	} prep_item_t;

	// z = x * h in GF(2^128), GCM bit order (bit 127 of the vector is x^0)
	function automatic logic [BLOCK_BITS-1:0] gf_mul(
		input logic [BLOCK_BITS-1:0] x,
		input logic [BLOCK_BITS-1:0] h
	);
		logic [BLOCK_BITS-1:0] a;
		logic [BLOCK_BITS-1:0] b;
		logic [PROD_BITS-1:0]  prod;
		logic [BLOCK_BITS+5:0] t;
		logic [5:0]            u;
		logic [12:0]           v;
		logic [BLOCK_BITS-1:0] c;
		logic [BLOCK_BITS-1:0] z;
		// reflect so that index i is the coefficient of x^i
		for (int i = 0; i < BLOCK_BITS; i++) begin
			a[i] = x[BLOCK_BITS-1-i];
			b[i] = h[BLOCK_BITS-1-i];
		end
		// carry-less product, one partial product per bit of a
		prod = '0;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			if (a[i]) begin
				prod = prod ^ ({{(BLOCK_BITS-1){1'b0}}, b} << i);
			end
		end
		// first fold of the upper half through x^7 + x^2 + x + 1
		t = '0;
		for (int j = 0; j < 8; j++) begin
			if (POLY_TOP[7-j]) begin
				t = t ^ ({7'd0, prod[PROD_BITS-1:BLOCK_BITS]} << j);
			end
		end
		// second fold of the few bits that spill past x^127
		u = t[BLOCK_BITS+5:BLOCK_BITS];
		v = '0;
		for (int j = 0; j < 8; j++) begin
			if (POLY_TOP[7-j]) begin
				v = v ^ ({7'd0, u} << j);
			end
		end
		c = prod[BLOCK_BITS-1:0] ^ t[BLOCK_BITS-1:0] ^ {{(BLOCK_BITS-13){1'b0}}, v};
		for (int i = 0; i < BLOCK_BITS; i++) begin
			z[BLOCK_BITS-1-i] = c[i];
		end
		return z;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ghash_if.sv
`default_nettype none

// block input channel
interface ghash_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [ghash_pkg::HALF_BITS-1:0] block_high;
	logic [ghash_pkg::HALF_BITS-1:0] block_low;
	logic [ghash_pkg::COUNT_W-1:0]   byte_count;

	modport source (output valid, kind, block_high, block_low, byte_count, input ready);
	modport sink   (input valid, kind, block_high, block_low, byte_count, output ready);
endinterface

// hash result channel
interface ghash_out_if;
	logic                          valid;
	logic                          ready;
	logic [ghash_pkg::HALF_BITS-1:0] hash_high;
	logic [ghash_pkg::HALF_BITS-1:0] hash_low;

	modport source (output valid, hash_high, hash_low, input ready);
	modport sink   (input valid, hash_high, hash_low, output ready);
endinterface

// register write channel
interface ghash_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ghash_pkg::CFG_IDX_W-1:0] index;
	logic [ghash_pkg::HALF_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ghash_prep.sv
`default_nettype none

module ghash_prep (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ghash_in_if.sink               blk_in,
	output logic                   item_valid,
	output ghash_pkg::prep_item_t  item,
	input  wire logic              item_ready
);
	import ghash_pkg::*;

	logic                  valid_s1;
	prep_item_t            item_s1;
	logic                  accept;
	logic                  keep;
	logic [COUNT_W-1:0]    nsat;
	logic [BLOCK_BITS-1:0] mask;
	prep_item_t            item_d;

	assign blk_in.ready = !valid_s1 || item_ready;
	assign accept       = blk_in.valid && blk_in.ready;

	// saturate the byte count and build the leading-byte mask
	always_comb begin
		nsat = (blk_in.byte_count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES)
		                                                   : blk_in.byte_count;
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			mask[BLOCK_BITS-1-8*j -: 8] = (COUNT_W'(j) < nsat) ? 8'hff : 8'h00;
		end
	end

	// classify the item; unknown kinds and empty data blocks are dropped
	always_comb begin
		item_d.kind   = KIND_FINISH;
		item_d.block  = {blk_in.block_high, blk_in.block_low} & mask;
		item_d.nbytes = nsat;
		keep          = 1'b0;
		case (blk_in.kind)
			KIND_AAD: begin
				item_d.kind = KIND_AAD;
				keep        = (nsat != '0);
			end
			KIND_TEXT: begin
				item_d.kind = KIND_TEXT;
				keep        = (nsat != '0);
			end
			KIND_FINISH: begin
				item_d.kind = KIND_FINISH;
				keep        = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

`default_nettype wire

FILE: hw/rtl/ghash_core.sv
`default_nettype none

module ghash_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ghash_cfg_if.sink              cfg,
	input  wire logic              item_valid,
	input  wire ghash_pkg::prep_item_t item,
	output logic                   item_ready,
	ghash_out_if.source            hash_out
);
	import ghash_pkg::*;

	logic [HALF_BITS-1:0]  key_high_q;
	logic [HALF_BITS-1:0]  key_low_q;
	logic [BLOCK_BITS-1:0] acc_q;
	logic [TOTAL_W-1:0]    aad_total_q;
	logic [TOTAL_W-1:0]    text_total_q;
	logic                  out_valid_q;
	logic [BLOCK_BITS-1:0] hash_q;
	logic                  is_finish;
	logic                  fire;
	logic [BLOCK_BITS-1:0] length_word;
	logic [BLOCK_BITS-1:0] mul_in;
	logic [BLOCK_BITS-1:0] prod;

	// key registers, writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_KEY_HIGH: key_high_q <= cfg.data;
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// a finish waits only while an earlier hash is still unclaimed
	assign is_finish  = (item.kind == KIND_FINISH);
	assign item_ready = !(is_finish && out_valid_q && !hash_out.ready);
	assign fire       = item_valid && item_ready;

	// length block holds both bit counts
	assign length_word = {aad_total_q, 3'b000, text_total_q, 3'b000};
	assign mul_in      = acc_q ^ (is_finish ? length_word : item.block);
	assign prod        = gf_mul(mul_in, {key_high_q, key_low_q});

	// accumulator and byte totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			aad_total_q  <= '0;
			text_total_q <= '0;
		end else if (fire) begin
			case (item.kind)
				KIND_AAD: begin
					acc_q       <= prod;
					aad_total_q <= aad_total_q + TOTAL_W'(item.nbytes);
				end
				KIND_TEXT: begin
					acc_q        <= prod;
					text_total_q <= text_total_q + TOTAL_W'(item.nbytes);
				end
				KIND_FINISH: begin
					acc_q        <= '0;
					aad_total_q  <= '0;
					text_total_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_finish) begin
			out_valid_q <= 1'b1;
		end else if (hash_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire && is_finish) begin
			hash_q <= prod;
		end
	end

	assign hash_out.valid     = out_valid_q;
	assign hash_out.hash_high = hash_q[BLOCK_BITS-1:HALF_BITS];
	assign hash_out.hash_low  = hash_q[HALF_BITS-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/ghash_accumulator_top.sv
`default_nettype none

// GHASH engine for GCM over GF(2^128). Load the hash key H through the cfg
// channel while the engine is idle (index 0 is the upper half, index 1 the
// lower half). Each transfer on blk_in carries one 16-byte block with a count
// of leading valid bytes (saturated at 16; bytes past it are zeroed): kind 0
// is associated data, kind 1 ciphertext, kind 2 finish. A data block with a
// zero count, or kind 3, is dropped. Finish folds in the length block, sends
// the hash on hash_out and clears the accumulator and byte totals. One block
// is accepted every clock cycle unless blk_in stalls; the limit is the
// combinational GF(2^128) multiply in the accumulator feedback loop. A hash
// passes through the input register and the result register before it is
// valid on hash_out, and blk_in stalls only when a finish reaches the core
// while the previous hash is still waiting on hash_out.
module ghash_accumulator_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ghash_cfg_if.sink   cfg,
	ghash_in_if.sink    blk_in,
	ghash_out_if.source hash_out
);
	import ghash_pkg::*;

	logic       item_valid;
	logic       item_ready;
	prep_item_t item;

	// input register: masking and classification
	ghash_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_in     (blk_in),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	// accumulator, multiplier and result register
	ghash_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.hash_out   (hash_out)
	);

endmodule

`default_nettype wire
